// ===== design/rwsr_pkg.sv =====
// ---------------------------------------------------------------------------
// rwsr_pkg
// shared types and constants for the rigid warp squared residual unit
// ---------------------------------------------------------------------------
package rwsr_pkg;

  localparam int MapDim = 256;
  localparam int IdxBits = 8;
  localparam int PixBits = 16;
  localparam int AccBits = 48;
  localparam logic [PixBits-1:0] PixThresh = 16'd6554;
  localparam logic [AccBits-1:0] AccMax = {AccBits{1'b1}};

  localparam logic REQ_MAP = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  localparam logic [2:0] REG_COS = 3'd0;
  localparam logic [2:0] REG_SIN = 3'd1;
  localparam logic [2:0] REG_TX = 3'd2;
  localparam logic [2:0] REG_TY = 3'd3;
  localparam logic [2:0] REG_LEVEL = 3'd4;
  localparam logic [2:0] REG_ROWS = 3'd5;
  localparam logic [2:0] REG_COLS = 3'd6;

  typedef struct packed {
    logic req_type;
    logic [7:0] pixel_row;
    logic [7:0] pixel_col;
    logic [15:0] pixel_value;
    logic start_req;
    logic last_in;
  } in_item_t;

  typedef struct packed {
    logic [47:0] residual_sum;
    logic contributed;
    logic last_out;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] cos_theta;
    logic signed [15:0] sin_theta;
    logic signed [23:0] trans_x;
    logic signed [23:0] trans_y;
    logic [2:0] level;
    logic [8:0] map_rows;
    logic [8:0] map_cols;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic is_map;
    logic active;
    logic in_bounds;
    logic [7:0] addr_row;
    logic [7:0] addr_col;
    logic [15:0] value;
    logic start_req;
    logic last_in;
  } cmd_t;

endpackage

// ===== design/rwsr_front.sv =====
// ---------------------------------------------------------------------------
// rwsr_front
// accepts requests, warps frame coordinates, hands commands to a queue
// ---------------------------------------------------------------------------
module rwsr_front (
  input  logic              clk,
  input  logic              rst,
  input  rwsr_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  rwsr_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output rwsr_pkg::cmd_t    cmd
);
  import rwsr_pkg::*;

  // stage 1: products, stage 2: sums and bounds
  logic v1;
  in_item_t it1;
  logic signed [33:0] pcx, psy, psx, pcy;
  logic signed [47:0] tx1, ty1;
  logic [8:0] rows1, cols1;
  logic v2;
  cmd_t cmd2;

  logic adv2, adv1;
  logic signed [8:0] x2, y2;
  logic signed [47:0] ax, ay, nax, nay;
  logic signed [25:0] mx, my;

  assign adv2 = !v2 || cmd_ready;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;
  assign cmd_valid = v2;
  assign cmd = cmd2;

  assign x2 = $signed({in_item.pixel_row, 1'b1});
  assign y2 = $signed({in_item.pixel_col, 1'b1});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
    if (adv1 && in_valid) begin
      it1 <= in_item;
      pcx <= 34'(cfg.cos_theta * $signed({1'b0, x2[8:0]}));
      psy <= 34'(cfg.sin_theta * $signed({1'b0, y2[8:0]}));
      psx <= 34'(cfg.sin_theta * $signed({1'b0, x2[8:0]}));
      pcy <= 34'(cfg.cos_theta * $signed({1'b0, y2[8:0]}));
      tx1 <= (48'(cfg.trans_x) <<< (5'd14 - 5'(cfg.level)));
      ty1 <= (48'(cfg.trans_y) <<< (5'd14 - 5'(cfg.level)));
      rows1 <= (cfg.map_rows > 9'd256) ? 9'd256 : cfg.map_rows;
      cols1 <= (cfg.map_cols > 9'd256) ? 9'd256 : cfg.map_cols;
    end
  end

  always_comb begin
    ax = (48'(pcx - psy) <<< 7) + tx1 + 48'sd2097152;
    ay = (48'(psx + pcy) <<< 7) + ty1 + 48'sd2097152;
    nax = -ax;
    nay = -ay;
    mx = ax[47] ? -26'(nax >>> 22) : 26'(ax >>> 22);
    my = ay[47] ? -26'(nay >>> 22) : 26'(ay >>> 22);
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      cmd2.is_map <= (it1.req_type == REQ_MAP);
      cmd2.active <= (it1.pixel_value >= PixThresh);
      cmd2.in_bounds <= !mx[25] && !my[25] && (mx < 26'(rows1)) && (my < 26'(cols1));
      cmd2.addr_row <= (it1.req_type == REQ_MAP) ? it1.pixel_row : mx[7:0];
      cmd2.addr_col <= (it1.req_type == REQ_MAP) ? it1.pixel_col : my[7:0];
      cmd2.value <= it1.pixel_value;
      cmd2.start_req <= it1.start_req;
      cmd2.last_in <= it1.last_in;
    end
  end

  a_v2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !cmd_ready |=> v2 && $stable(cmd2))
    else $error("command changed while stalled");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    v1 && adv2 |=> v2)
    else $error("stage two lost a request");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> in_ready)
    else $error("front stalled while empty");

endmodule

// ===== design/rwsr_queue.sv =====
// ---------------------------------------------------------------------------
// rwsr_queue
// short command queue between front and back
// ---------------------------------------------------------------------------
module rwsr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  rwsr_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output rwsr_pkg::cmd_t rd_data
);
  import rwsr_pkg::*;

  cmd_t slots [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic do_wr, do_rd;

  assign wr_ready = count != 3'd4;
  assign rd_valid = count != 3'd0;
  assign rd_data = slots[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= wp + 2'd1;
      if (do_rd) rp <= rp + 2'd1;
      count <= count + 3'(do_wr) - 3'(do_rd);
    end
    if (do_wr) slots[wp] <= wr_data;
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("queue count overflow");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (count == 3'd0 || count == 3'd4) |-> wp == rp)
    else $error("queue pointers inconsistent");
  a_inc: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + 3'd1)
    else $error("queue count missed a write");

endmodule

// ===== design/rwsr_back.sv =====
// ---------------------------------------------------------------------------
// rwsr_back
// map memory, squared difference and saturating accumulation
// ---------------------------------------------------------------------------
module rwsr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  rwsr_pkg::cmd_t      cmd,
  output logic                empty,
  input  logic                pop,
  output rwsr_pkg::out_item_t out_item
);
  import rwsr_pkg::*;

  logic [PixBits-1:0] mem [MapDim*MapDim];
  logic [PixBits-1:0] rd_q;

  // stage a: memory read, stage b: absolute difference, stage c: square and accumulate
  logic va, vb, vo;
  cmd_t ca;
  logic [15:0] diff_b;
  cmd_t cb;
  logic [31:0] sq;
  logic [AccBits-1:0] acc, base, sum_full;
  logic [AccBits:0] wide;
  logic [15:0] mval;
  out_item_t oreg;
  logic adv_o, adv_b, adv_a;

  assign adv_o = !vo || pop;
  assign adv_b = !vb || adv_o;
  assign adv_a = !va || adv_b;
  assign cmd_ready = adv_a;
  assign empty = !vo;
  assign out_item = oreg;

  always_ff @(posedge clk) begin
    if (adv_a && cmd_valid) begin
      if (cmd.is_map) mem[{cmd.addr_row, cmd.addr_col}] <= cmd.value;
      rd_q <= mem[{cmd.addr_row, cmd.addr_col}];
      ca <= cmd;
    end
  end

  assign mval = ca.in_bounds ? rd_q : 16'd0;

  always_ff @(posedge clk) begin
    if (adv_b && va) begin
      cb <= ca;
      diff_b <= (mval >= ca.value) ? mval - ca.value : ca.value - mval;
    end
  end

  assign sq = 32'(diff_b) * 32'(diff_b);
  assign base = (cb.start_req && !cb.is_map) ? '0 : acc;
  assign wide = {1'b0, base} + {17'd0, sq};
  assign sum_full = wide[AccBits] ? AccMax : wide[AccBits-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vo <= 1'b0;
      acc <= '0;
    end else begin
      if (adv_a) va <= cmd_valid;
      if (adv_b) vb <= va;
      if (adv_o) vo <= vb;
      if (adv_o && vb && !cb.is_map) acc <= cb.active ? sum_full : base;
    end
    if (adv_o && vb) begin
      if (cb.is_map) begin
        oreg <= '{residual_sum: acc, contributed: 1'b0, last_out: 1'b0};
      end else begin
        oreg.residual_sum <= cb.active ? sum_full : base;
        oreg.contributed <= cb.active;
        oreg.last_out <= cb.last_in;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    vo && !pop |=> vo && $stable(oreg))
    else $error("result changed while waiting");
  a_acc_map: assert property (@(posedge clk) disable iff (rst)
    adv_o && vb && cb.is_map |=> acc == $past(acc))
    else $error("map write touched accumulator");
  a_contrib: assert property (@(posedge clk) disable iff (rst)
    vo && oreg.contributed |-> !$isunknown(oreg.residual_sum))
    else $error("contribution without sum");

endmodule

// ===== design/rigid_warp_squared_residual_unit.sv =====
// ---------------------------------------------------------------------------
// rigid_warp_squared_residual_unit
// scan-matching squared residual of a rigid warp against a stored map
// ---------------------------------------------------------------------------
// structure: front pipeline, 4-entry queue, back pipeline
// throughput: one request per cycle while pop keeps the output drained
// reset: pose registers to identity, map size 256x256, accumulator zero
// map memory contents are undefined until written
module rigid_warp_squared_residual_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  rwsr_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output rwsr_pkg::out_item_t out_item
);
  import rwsr_pkg::*;

  cfg_t cfg;
  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready, in_ready;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign full = !in_ready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{cos_theta: 16'sd16384, sin_theta: '0, trans_x: '0, trans_y: '0,
               level: '0, map_rows: 9'd256, map_cols: 9'd256};
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_COS: cfg.cos_theta <= pwdata[15:0];
        REG_SIN: cfg.sin_theta <= pwdata[15:0];
        REG_TX: cfg.trans_x <= pwdata[23:0];
        REG_TY: cfg.trans_y <= pwdata[23:0];
        REG_LEVEL: cfg.level <= pwdata[2:0];
        REG_ROWS: cfg.map_rows <= pwdata[8:0];
        REG_COLS: cfg.map_cols <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COS: prdata = 32'($unsigned(cfg.cos_theta));
      REG_SIN: prdata = 32'($unsigned(cfg.sin_theta));
      REG_TX: prdata = 32'($unsigned(cfg.trans_x));
      REG_TY: prdata = 32'($unsigned(cfg.trans_y));
      REG_LEVEL: prdata = 32'(cfg.level);
      REG_ROWS: prdata = 32'(cfg.map_rows);
      REG_COLS: prdata = 32'(cfg.map_cols);
      default: prdata = '0;
    endcase
  end

  rwsr_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(push), .in_ready(in_ready), .in_item(in_item),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  rwsr_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  rwsr_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

endmodule
